// ----- design/assert_macros.svh -----
// Assertion helpers for the RTL; included by the top-level file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising edge outside reset.
`define VPCL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define VPCL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define VPCL_ASSERT(label, clk, rst_n, prop, msg)
`define VPCL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- design/vpcl_pkg.sv -----
`timescale 1ns / 1ps

package vpcl_pkg;

    // Field widths and default table depth
    localparam int MAX_CODE_BITS      = 16;
    localparam int TABLE_ENTRIES_DEF  = 256;
    localparam int LEN_W              = 5;
    localparam int VALUE_W            = 32;
    localparam int SLOT_W             = 8;
    localparam int GS_W               = 9;
    localparam int CFG_DATA_W         = 9;

    // Request modes
    localparam logic [1:0] MODE_DECODE     = 2'd0;
    localparam logic [1:0] MODE_LOAD_ENTRY = 2'd1;
    localparam logic [1:0] MODE_LOAD_GROUP = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    // Configuration register indexes
    localparam logic CFG_MAX_LEN     = 1'b0;
    localparam logic CFG_ENTRY_TOTAL = 1'b1;

    // One code table entry
    typedef struct packed {
        logic [MAX_CODE_BITS-1:0] code;
        logic [LEN_W-1:0]         len;
        logic [VALUE_W-1:0]       value;
    } t_entry;

    // Controls broadcast to the length cells
    typedef struct packed {
        logic capture;   // decode request accepted: latch window bit, seed token
        logic advance;   // move the token to the next length
        logic gs_write;  // group start load request accepted
    } t_cell_ctrl;

endpackage

// ----- design/vpcl_table.sv -----
`timescale 1ns / 1ps

module vpcl_table #(
    parameter int DEPTH = vpcl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  vpcl_pkg::t_entry         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output vpcl_pkg::t_entry         o_rdata
);
    import vpcl_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/vpcl_cell.sv -----
`timescale 1ns / 1ps

module vpcl_cell #(
    parameter int INDEX = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vpcl_pkg::t_cell_ctrl                i_ctrl,
    input  logic [vpcl_pkg::SLOT_W-1:0]         i_slot,
    input  logic [vpcl_pkg::GS_W-1:0]           i_group_start,
    input  logic                                i_bit,
    input  logic [vpcl_pkg::MAX_CODE_BITS-1:0]  i_prefix,
    input  logic                                i_tok,
    output logic [vpcl_pkg::MAX_CODE_BITS-1:0]  o_prefix,
    output logic                                o_tok,
    output logic [vpcl_pkg::GS_W-1:0]           o_sel_start,
    output logic [vpcl_pkg::MAX_CODE_BITS-1:0]  o_sel_prefix
);
    import vpcl_pkg::*;

    logic [GS_W-1:0] r_start;
    logic            r_bit;
    logic            r_tok;

    // Group start for this code length (length = INDEX + 1)
    always_ff @(posedge i_clk) begin
        if (i_ctrl.gs_write && (i_slot == SLOT_W'(INDEX))) begin
            r_start <= i_group_start;
        end
    end

    // Window bit at this position, latched per decode
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_bit <= i_bit;
        end
    end

    // Length token: seeded in the first cell, handed right on advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else if (i_ctrl.capture) begin
            r_tok <= (INDEX == 0);
        end else if (i_ctrl.advance) begin
            r_tok <= i_tok;
        end
    end

    // Leading INDEX+1 window bits, right aligned
    assign o_prefix     = {i_prefix[MAX_CODE_BITS-2:0], r_bit};
    assign o_tok        = r_tok;
    assign o_sel_start  = r_tok ? r_start : '0;
    assign o_sel_prefix = r_tok ? o_prefix : '0;

endmodule

// ----- design/vlc_prefix_code_lookup_top.sv -----
`timescale 1ns / 1ps

// Prefix code table decoder.
// Requests: pulse i_start with i_mode while o_busy is low. Load-entry and
// load-group requests are written at the accepting edge, give no result and
// leave o_busy low. A decode request raises o_busy and walks the code lengths
// one cell at a time along a row of length cells; each cell holds its group
// start and one window bit. Each length is tried in S_LEN; table entries are
// compared one after another in S_CMP, since they come from a single
// registered read port. Requests run one at a time.
// The result shows on o_status / o_symbol_value / o_code_length for exactly
// one cycle with o_strobe; there is no back-pressure on the result side.
// Configuration: i_cfg_we writes register i_cfg_index (0 max code length,
// 1 entry total) at once; write only while idle.
// Reset (i_rst_n low, synchronous) returns to idle, max code length 16 and
// entry total 0. Table contents and group starts are not cleared and must be
// loaded before use.
module vlc_prefix_code_lookup_top #(
    parameter int TABLE_ENTRIES = vpcl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [1:0]                          i_mode,
    input  logic [vpcl_pkg::MAX_CODE_BITS-1:0]  i_bit_window,
    input  logic [vpcl_pkg::LEN_W-1:0]          i_bits_available,
    input  logic [vpcl_pkg::SLOT_W-1:0]         i_slot,
    input  logic [vpcl_pkg::MAX_CODE_BITS-1:0]  i_entry_code,
    input  logic [vpcl_pkg::LEN_W-1:0]          i_entry_length,
    input  logic [vpcl_pkg::VALUE_W-1:0]        i_entry_value,
    input  logic [vpcl_pkg::GS_W-1:0]           i_group_start,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [vpcl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_strobe,
    output logic [1:0]                          o_status,
    output logic [vpcl_pkg::VALUE_W-1:0]        o_symbol_value,
    output logic [vpcl_pkg::LEN_W-1:0]          o_code_length
);
    import vpcl_pkg::*;

`include "assert_macros.svh"

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int TOT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int CNT_W   = (TOT_W > GS_W) ? TOT_W : GS_W;
    localparam int N_CELLS = MAX_CODE_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_CMP
    } t_state;

    // Configuration registers
    logic [LEN_W-1:0] r_max_len;
    logic [GS_W-1:0]  r_entry_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len     <= LEN_W'(16);
            r_entry_total <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_LEN:     r_max_len     <= i_cfg_data[LEN_W-1:0];
                CFG_ENTRY_TOTAL: r_entry_total <= i_cfg_data[GS_W-1:0];
                default:         r_max_len     <= r_max_len;
            endcase
        end
    end

    // Sequencer registers
    t_state           r_state;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_limit;
    logic [LEN_W-1:0] r_avail;
    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] r_j;
    logic             r_strobe;
    logic [1:0]       r_status;
    logic [VALUE_W-1:0] r_value;
    logic [LEN_W-1:0]   r_length;

    t_state             n_state;
    logic [LEN_W-1:0]   n_len;
    logic [CNT_W-1:0]   n_j;
    logic               n_strobe;
    logic [1:0]         n_status;
    logic [VALUE_W-1:0] n_value;
    logic [LEN_W-1:0]   n_length;

    logic               accept;
    logic               rd_en;
    logic [CNT_W-1:0]   rd_idx;
    logic               advance;
    logic [CNT_W-1:0]   slot_ext;
    logic [CNT_W-1:0]   start_ext;
    logic [CNT_W-1:0]   j_next;
    logic               tbl_we;
    t_entry             wr_entry;
    t_entry             rd_entry;
    t_cell_ctrl         cell_ctrl;

    assign accept   = i_start && (r_state == S_IDLE);
    assign slot_ext = CNT_W'(i_slot);
    assign tbl_we   = accept && (i_mode == MODE_LOAD_ENTRY)
                      && (slot_ext < CNT_W'(TABLE_ENTRIES));
    assign wr_entry = '{code: i_entry_code, len: i_entry_length, value: i_entry_value};

    assign cell_ctrl.capture  = accept && (i_mode == MODE_DECODE);
    assign cell_ctrl.advance  = advance;
    assign cell_ctrl.gs_write = accept && (i_mode == MODE_LOAD_GROUP);

    // Row of length cells
    logic [MAX_CODE_BITS-1:0] w_prefix [N_CELLS+1];
    logic                     w_tok    [N_CELLS+1];
    logic [GS_W-1:0]          w_sel_start  [N_CELLS];
    logic [MAX_CODE_BITS-1:0] w_sel_prefix [N_CELLS];
    logic [N_CELLS-1:0]       tok_vec;

    assign w_prefix[0] = '0;
    assign w_tok[0]    = 1'b0;

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        vpcl_cell #(
            .INDEX(g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (cell_ctrl),
            .i_slot       (i_slot),
            .i_group_start(i_group_start),
            .i_bit        (i_bit_window[MAX_CODE_BITS-1-g]),
            .i_prefix     (w_prefix[g]),
            .i_tok        (w_tok[g]),
            .o_prefix     (w_prefix[g+1]),
            .o_tok        (w_tok[g+1]),
            .o_sel_start  (w_sel_start[g]),
            .o_sel_prefix (w_sel_prefix[g])
        );
        assign tok_vec[g] = w_tok[g+1];
    end

    // Fields of the cell holding the token
    logic [GS_W-1:0]          sel_start;
    logic [MAX_CODE_BITS-1:0] sel_prefix;

    always_comb begin
        sel_start  = '0;
        sel_prefix = '0;
        for (int k = 0; k < N_CELLS; k++) begin
            sel_start  = sel_start  | w_sel_start[k];
            sel_prefix = sel_prefix | w_sel_prefix[k];
        end
    end

    // Code table memory
    vpcl_table #(
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_waddr(slot_ext[IDX_W-1:0]),
        .i_wdata(wr_entry),
        .i_re   (rd_en),
        .i_raddr(rd_idx[IDX_W-1:0]),
        .o_rdata(rd_entry)
    );

    assign start_ext = CNT_W'(sel_start);
    assign j_next    = r_j + CNT_W'(1);

    // Next-state logic of the scan
    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_j      = r_j;
        n_strobe = 1'b0;
        n_status = r_status;
        n_value  = r_value;
        n_length = r_length;
        rd_en    = 1'b0;
        rd_idx   = '0;
        advance  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_mode == MODE_DECODE)) begin
                    n_state = S_LEN;
                    n_len   = LEN_W'(1);
                end
            end
            S_LEN: begin
                priority if (r_len > r_limit) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_status = ST_MISSING;
                    n_value  = '0;
                    n_length = '0;
                end else if (r_len > r_avail) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_status = ST_SHORT;
                    n_value  = '0;
                    n_length = '0;
                end else if (start_ext < r_total) begin
                    rd_en   = 1'b1;
                    rd_idx  = start_ext;
                    n_j     = start_ext;
                    n_state = S_CMP;
                end else begin
                    advance = 1'b1;
                    n_len   = r_len + LEN_W'(1);
                end
            end
            S_CMP: begin
                priority if (rd_entry.len != r_len) begin
                    advance = 1'b1;
                    n_len   = r_len + LEN_W'(1);
                    n_state = S_LEN;
                end else if (rd_entry.code == sel_prefix) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_status = ST_OK;
                    n_value  = rd_entry.value;
                    n_length = r_len;
                end else if (j_next < r_total) begin
                    rd_en  = 1'b1;
                    rd_idx = j_next;
                    n_j    = j_next;
                end else begin
                    advance = 1'b1;
                    n_len   = r_len + LEN_W'(1);
                    n_state = S_LEN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_len    <= n_len;
            r_j      <= n_j;
            r_status <= n_status;
            r_value  <= n_value;
            r_length <= n_length;
            if (cell_ctrl.capture) begin
                r_limit <= (r_max_len > LEN_W'(MAX_CODE_BITS))
                           ? LEN_W'(MAX_CODE_BITS) : r_max_len;
                r_avail <= (i_bits_available > LEN_W'(MAX_CODE_BITS))
                           ? LEN_W'(MAX_CODE_BITS) : i_bits_available;
                r_total <= (CNT_W'(r_entry_total) > CNT_W'(TABLE_ENTRIES))
                           ? CNT_W'(TABLE_ENTRIES) : CNT_W'(r_entry_total);
            end
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_symbol_value = r_value;
    assign o_code_length  = r_length;

    // Checks
    `VPCL_ASSERT(a_tok_onehot, i_clk, i_rst_n, $onehot0(tok_vec), "more than one length token")
    `VPCL_ASSERT_IMPLY(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, $past(o_busy) && !o_busy, "result without a decode in flight")
    `VPCL_ASSERT_IMPLY(a_ok_has_length, i_clk, i_rst_n, o_strobe && (o_status == ST_OK), (o_code_length != '0) && (o_code_length <= LEN_W'(MAX_CODE_BITS)), "success with bad code length")
    `VPCL_ASSERT_IMPLY(a_fail_zeroed, i_clk, i_rst_n, o_strobe && (o_status != ST_OK), (o_symbol_value == '0) && (o_code_length == '0), "failure result not zeroed")
    `VPCL_ASSERT_IMPLY(a_scan_in_range, i_clk, i_rst_n, r_state == S_CMP, (r_j < r_total) && (r_len <= r_limit), "scan index out of range")

endmodule
